### sv/irp_pkg.sv
// irp_pkg: shared types, constants and helpers for the iRprop+ weight update core
// holds the item structs, the stored record layout and the saturation helper
// no dependencies
package irp_pkg;

	localparam int IDX_W       = 10;
	localparam int NUM_WEIGHTS = 1 << IDX_W;
	localparam int FRAC_BITS   = 16;
	localparam int WORD_W      = 32;
	localparam int GROW_W      = 18;
	localparam int SHRINK_W    = 17;
	localparam int STEP_CFG_W  = 31;
	localparam int PROD_W      = WORD_W + GROW_W;
	localparam int SCALED_W    = PROD_W - FRAC_BITS;
	localparam int WIDE_W      = WORD_W + 2;
	localparam int PADDR_W     = 5;

	// reset values of the configuration registers
	localparam logic [GROW_W-1:0]     GROW_RESET     = GROW_W'(78643);
	localparam logic [SHRINK_W-1:0]   SHRINK_RESET   = SHRINK_W'(32768);
	localparam logic [STEP_CFG_W-1:0] FLOOR_RESET    = STEP_CFG_W'(0);
	localparam logic [STEP_CFG_W-1:0] CEILING_RESET  = STEP_CFG_W'(3276800);
	localparam logic [STEP_CFG_W-1:0] INIT_STEP_RESET = STEP_CFG_W'(6554);

	// register index codes, byte address / 4
	typedef enum logic [2:0] {
		REG_GROW      = 3'd0,
		REG_SHRINK    = 3'd1,
		REG_FLOOR     = 3'd2,
		REG_CEILING   = 3'd3,
		REG_INIT_STEP = 3'd4
	} cfg_reg_t;

	// stored gradient sign codes
	localparam logic [1:0] SGN_ZERO = 2'b00;
	localparam logic [1:0] SGN_POS  = 2'b01;
	localparam logic [1:0] SGN_NEG  = 2'b11;

	// what an item does to its step
	typedef enum logic [1:0] {
		CLS_NONE   = 2'd0,
		CLS_GROW   = 2'd1,
		CLS_SHRINK = 2'd2,
		CLS_HOLD   = 2'd3
	} upd_class_t;

	typedef struct packed {
		logic                     kind;
		logic [IDX_W-1:0]         weight_index;
		logic signed [WORD_W-1:0] gradient;
		logic signed [WORD_W-1:0] initial_weight;
		logic                     frozen;
		logic                     error_increased;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]         out_index;
		logic signed [WORD_W-1:0] new_weight;
		logic signed [WORD_W-1:0] applied_change;
	} out_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] weight;
		logic [WORD_W-1:0]        step;
		logic [1:0]               last_sign;
		logic signed [WORD_W-1:0] last_change;
	} record_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(2147483647);
		// most negative word, sign extended
		lo = ~hi;
		if (v > hi) begin
			sat_word = hi[WORD_W-1:0];
		end else if (v < lo) begin
			sat_word = lo[WORD_W-1:0];
		end else begin
			sat_word = v[WORD_W-1:0];
		end
	endfunction

endpackage

### sv/irprop_plus_weight_update_core.sv
// irprop_plus_weight_update_core: iRprop+ per-weight update engine, Q16.16 records
// depends on irp_pkg; holds the record memory and the four-stage update pipeline
// throughput: one item per clock, busy never rises; any mix of loads and updates,
// same index back to back included, streams without a bubble
// done rises for an item once it has passed the record read, step multiply,
// step clamp and change, weight add and write back, then the output register
// reset: arst_n clears the stage valid bits and restores register defaults; the record
// memory is not cleared, a record must be loaded before it is updated
module irprop_plus_weight_update_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  irp_pkg::in_item_t           cmd,
	output logic                        done,
	output irp_pkg::out_item_t          result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [irp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import irp_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [GROW_W-1:0]     grow_q;
	logic [SHRINK_W-1:0]   shrink_q;
	logic [STEP_CFG_W-1:0] floor_q;
	logic [STEP_CFG_W-1:0] ceiling_q;
	logic [STEP_CFG_W-1:0] init_step_q;
	cfg_reg_t              reg_sel;
	logic                  cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grow_q      <= GROW_RESET;
			shrink_q    <= SHRINK_RESET;
			floor_q     <= FLOOR_RESET;
			ceiling_q   <= CEILING_RESET;
			init_step_q <= INIT_STEP_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_GROW:      grow_q      <= pwdata[GROW_W-1:0];
				REG_SHRINK:    shrink_q    <= pwdata[SHRINK_W-1:0];
				REG_FLOOR:     floor_q     <= pwdata[STEP_CFG_W-1:0];
				REG_CEILING:   ceiling_q   <= pwdata[STEP_CFG_W-1:0];
				REG_INIT_STEP: init_step_q <= pwdata[STEP_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_GROW:      prdata = 32'(grow_q);
			REG_SHRINK:    prdata = 32'(shrink_q);
			REG_FLOOR:     prdata = 32'(floor_q);
			REG_CEILING:   prdata = 32'(ceiling_q);
			REG_INIT_STEP: prdata = 32'(init_step_q);
			default:       prdata = 32'd0;
		endcase
	end

	// ------------------------------------------------------------------
	// handshake: the pipeline never stalls, so every start is taken
	// ------------------------------------------------------------------
	logic acc;

	assign busy = 1'b0;
	assign acc  = start & ~busy;

	// ------------------------------------------------------------------
	// stage registers
	// ------------------------------------------------------------------
	// stage 1: item and raw memory read
	logic             v_s1;
	in_item_t         item_s1;
	record_t          rd_s1;

	// stage 2: step product and resolved record operands
	logic                     v_s2;
	logic                     load_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic [1:0]               gsign_s2;
	logic                     err_s2;
	upd_class_t               cls_s2;
	logic [1:0]               sign_new_s2;
	logic [WORD_W-1:0]        step_op_s2;
	logic signed [WORD_W-1:0] chg_op_s2;
	logic signed [WORD_W-1:0] wt_op_s2;
	logic signed [WORD_W-1:0] init_w_s2;
	logic [PROD_W-1:0]        prod_s2;

	// stage 3: new step, sign and change; weight add
	logic                     v_s3;
	logic                     load_s3;
	logic [IDX_W-1:0]         idx_s3;
	logic [WORD_W-1:0]        step_s3;
	logic [1:0]               sign_s3;
	logic signed [WORD_W-1:0] change_s3;
	logic signed [WORD_W-1:0] wt_op_s3;
	logic signed [WORD_W-1:0] init_w_s3;

	// stage 4: written record, also the result register
	logic             v_s4;
	logic [IDX_W-1:0] idx_s4;
	record_t          rec_s4;

	// ------------------------------------------------------------------
	// record memory: one read at accept, one write from stage 3
	// ------------------------------------------------------------------
	record_t rec_mem [NUM_WEIGHTS];
	record_t rec_new_s3;

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= rec_mem[cmd.weight_index];
		end
		if (v_s3) begin
			rec_mem[idx_s3] <= rec_new_s3;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: forward newer record values, classify, multiply
	// ------------------------------------------------------------------
	logic [WORD_W-1:0]        step_nxt_s2;
	logic signed [WORD_W-1:0] change_nxt_s2;
	logic signed [WORD_W-1:0] w_new_s3;

	logic [WORD_W-1:0]        step_r;
	logic [1:0]               sign_r;
	logic signed [WORD_W-1:0] chg_r;
	logic signed [WORD_W-1:0] wt_r;
	logic [1:0]               gsign;
	upd_class_t               cls;
	logic [1:0]               sign_new;
	logic [GROW_W-1:0]        factor;
	logic [PROD_W-1:0]        prod;

	always_comb begin
		// memory is oldest, then the record written last edge, then the
		// items still in flight; the stage 2 item is the newest
		step_r = rd_s1.step;
		sign_r = rd_s1.last_sign;
		chg_r  = rd_s1.last_change;
		wt_r   = rd_s1.weight;
		if (v_s4 && idx_s4 == item_s1.weight_index) begin
			step_r = rec_s4.step;
			sign_r = rec_s4.last_sign;
			chg_r  = rec_s4.last_change;
			wt_r   = rec_s4.weight;
		end
		if (v_s3 && idx_s3 == item_s1.weight_index) begin
			step_r = step_s3;
			sign_r = sign_s3;
			chg_r  = change_s3;
			wt_r   = w_new_s3;
		end
		// stage 2 weight is not known yet; it is picked up again in stage 3
		if (v_s2 && idx_s2 == item_s1.weight_index) begin
			step_r = step_nxt_s2;
			sign_r = sign_new_s2;
			chg_r  = change_nxt_s2;
		end
	end

	always_comb begin
		if (item_s1.gradient > 0) begin
			gsign = SGN_POS;
		end else if (item_s1.gradient < 0) begin
			gsign = SGN_NEG;
		end else begin
			gsign = SGN_ZERO;
		end

		if (item_s1.kind || item_s1.frozen) begin
			cls = CLS_NONE;
		end else if (gsign != SGN_ZERO && sign_r != SGN_ZERO) begin
			cls = (gsign == sign_r) ? CLS_GROW : CLS_SHRINK;
		end else begin
			cls = CLS_HOLD;
		end

		// a sign flip counts as a zero gradient, a load starts from zero
		if (item_s1.kind || cls == CLS_SHRINK) begin
			sign_new = SGN_ZERO;
		end else begin
			sign_new = gsign;
		end

		factor = (cls == CLS_GROW) ? grow_q : GROW_W'(shrink_q);
		prod   = PROD_W'(step_r) * PROD_W'(factor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= cmd;
		end
		load_s2     <= item_s1.kind;
		idx_s2      <= item_s1.weight_index;
		gsign_s2    <= gsign;
		err_s2      <= item_s1.error_increased;
		cls_s2      <= cls;
		sign_new_s2 <= sign_new;
		step_op_s2  <= item_s1.kind ? WORD_W'(init_step_q) : step_r;
		chg_op_s2   <= chg_r;
		wt_op_s2    <= wt_r;
		init_w_s2   <= item_s1.initial_weight;
		prod_s2     <= prod;
	end

	// ------------------------------------------------------------------
	// stage 2: scale and clamp the step, pick the change
	// ------------------------------------------------------------------
	logic [SCALED_W-1:0]      scaled;
	logic signed [WIDE_W-1:0] step_wide;
	logic signed [WIDE_W-1:0] chg_wide;

	always_comb begin
		scaled = prod_s2[PROD_W-1:FRAC_BITS];
		case (cls_s2)
			CLS_GROW: begin
				step_nxt_s2 = (scaled > SCALED_W'(ceiling_q)) ? WORD_W'(ceiling_q)
				                                              : scaled[WORD_W-1:0];
			end
			CLS_SHRINK: begin
				step_nxt_s2 = (scaled < SCALED_W'(floor_q)) ? WORD_W'(floor_q)
				                                            : scaled[WORD_W-1:0];
			end
			default: step_nxt_s2 = step_op_s2;
		endcase

		step_wide = $signed({2'b00, step_nxt_s2});
		case (cls_s2)
			CLS_GROW: begin
				chg_wide = (gsign_s2 == SGN_POS) ? -step_wide : step_wide;
			end
			CLS_SHRINK: begin
				// undo last change only when the error went up
				chg_wide = err_s2 ? -WIDE_W'(chg_op_s2) : '0;
			end
			CLS_HOLD: begin
				if (gsign_s2 == SGN_POS) begin
					chg_wide = -step_wide;
				end else if (gsign_s2 == SGN_NEG) begin
					chg_wide = step_wide;
				end else begin
					chg_wide = '0;
				end
			end
			default: chg_wide = '0;
		endcase
		change_nxt_s2 = sat_word(chg_wide);
	end

	always_ff @(posedge clk) begin
		load_s3   <= load_s2;
		idx_s3    <= idx_s2;
		step_s3   <= step_nxt_s2;
		sign_s3   <= sign_new_s2;
		change_s3 <= change_nxt_s2;
		wt_op_s3  <= wt_op_s2;
		init_w_s3 <= init_w_s2;
	end

	// ------------------------------------------------------------------
	// stage 3: weight add with saturation, write back
	// ------------------------------------------------------------------
	logic signed [WORD_W-1:0] wt_use;

	always_comb begin
		// the item that sat in stage 2 beside us in stage 1 is now in stage 4
		wt_use = (v_s4 && idx_s4 == idx_s3) ? rec_s4.weight : wt_op_s3;
		if (load_s3) begin
			w_new_s3 = init_w_s3;
		end else begin
			w_new_s3 = sat_word(WIDE_W'(wt_use) + WIDE_W'(change_s3));
		end
		rec_new_s3.weight      = w_new_s3;
		rec_new_s3.step        = step_s3;
		rec_new_s3.last_sign   = sign_s3;
		rec_new_s3.last_change = change_s3;
	end

	always_ff @(posedge clk) begin
		idx_s4 <= idx_s3;
		rec_s4 <= rec_new_s3;
	end

	// ------------------------------------------------------------------
	// result ports
	// ------------------------------------------------------------------
	assign done                  = v_s4;
	assign result.out_index      = idx_s4;
	assign result.new_weight     = rec_s4.weight;
	assign result.applied_change = rec_s4.last_change;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted item did not produce a result four edges later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without a matching accepted item");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.out_index == $past(cmd.weight_index, 4)))
		else $error("result index does not follow the item");

	a_grow_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && cls_s2 == CLS_GROW) |=> (step_s3 <= WORD_W'(ceiling_q)))
		else $error("grown step above the ceiling");

endmodule
